FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ste_pkg.sv
// Package for the session table: sizes, codes and the controller/datapath bundles.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ste_pkg;

    localparam int SLOTS    = 8;
    localparam int ID_FIRST = 1;
    localparam int ID_LAST  = 65535;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TS_W  = 48;
    localparam int ID_W  = 16;

    typedef enum logic [1:0] {
        CMD_LOGIN    = 2'd0,
        CMD_LOGOUT   = 2'd1,
        CMD_VALIDATE = 2'd2,
        CMD_BAD      = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_CRED     = 3'd1,
        ST_EXPIRED  = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4,
        ST_PARAM    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        REG_TIMEOUT_EN = 2'd0,
        REG_TIMEOUT    = 2'd1,
        REG_ADMIN_HASH = 2'd2,
        REG_MAX_LEN    = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        RES_NONE     = 2'd0,
        RES_LOGIN    = 2'd1,
        RES_VALIDATE = 2'd2
    } t_res;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SWEEP  = 2'd1,
        S_DECIDE = 2'd2,
        S_DRAW   = 2'd3
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    sweep;
        logic    logout_clr;
        logic    validate_upd;
        logic    validate_exp;
        logic    draw_step;
        logic    finish;
        t_status status;
        t_res    res;
    } t_dp_ctrl;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd cmd;
        logic plen_bad;
        logic not_admin;
        logic hash_bad;
        logic full;
        logic found;
        logic expired;
        logic id_free;
        logic last_try;
    } t_dp_stat;

endpackage

FILE: sv/session_table_with_expiry.sv
// Top level of the session table with expiry.
// Depends on ste_pkg, ste_ctrl and ste_datapath.
//
// Usage:
//   A request (login, logout or validate) is taken at a rising edge where
//   start is high and busy is low; its fields are sampled at that edge.
//   Exactly one result follows, shown for one cycle with o_done high. The
//   receiver cannot stall it, so it must take the result in that cycle.
//   Sequence: the request is latched, then the sweep and the decision
//   states follow, and the result register raises o_done. A granted login
//   also passes through the draw state, where the sequencer tries one
//   identifier candidate per cycle against all slots at once until one is
//   free or the last try is reached. busy falls as o_done rises, so a new
//   request can be taken in the cycle its predecessor's result is shown.
//   Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data
//   at any edge, and should be changed only while the block is idle.
//   Reset (i_rst_n low, synchronous) empties the table, loads the register
//   defaults and restarts the identifier counter at its first value.
`timescale 1ns / 1ps

module session_table_with_expiry import ste_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [47:0] i_now_ms,
    input  logic [15:0] i_sess_id,
    input  logic        i_user_is_admin,
    input  logic [31:0] i_password_hash,
    input  logic [7:0]  i_password_len,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [15:0] o_granted_id,
    output logic [47:0] o_login_stamp,
    output logic [47:0] o_activity_stamp,
    output logic [47:0] o_expiry_stamp
);

    t_dp_ctrl ctrl;
    t_dp_stat stat;

    // Sequencer.
    ste_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_busy  (busy)
    );

    // Table and result registers.
    ste_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_command        (i_command),
        .i_now_ms         (i_now_ms),
        .i_sess_id        (i_sess_id),
        .i_user_is_admin  (i_user_is_admin),
        .i_password_hash  (i_password_hash),
        .i_password_len   (i_password_len),
        .i_ctrl           (ctrl),
        .o_stat           (stat),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_granted_id     (o_granted_id),
        .o_login_stamp    (o_login_stamp),
        .o_activity_stamp (o_activity_stamp),
        .o_expiry_stamp   (o_expiry_stamp)
    );

endmodule

FILE: sv/ste_ctrl.sv
// Sequencer of the session table: decides each request's path and status.
// Depends on ste_pkg; drives ste_datapath through t_dp_ctrl.
`timescale 1ns / 1ps

module ste_ctrl import ste_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_ctrl o_ctrl,
    output logic     o_busy
);

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_SWEEP;
            end
            S_SWEEP: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_stat.cmd == CMD_LOGIN && !i_stat.plen_bad && !i_stat.not_admin
                    && !i_stat.hash_bad && !i_stat.full) begin
                    n_state = S_DRAW;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DRAW: begin
                if (i_stat.id_free || i_stat.last_try) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_ctrl = '0;
        o_ctrl.status = ST_OK;
        o_ctrl.res    = RES_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_ctrl.capture = i_start;
            end
            S_SWEEP: begin
                // Only a login past the cheap checks, or a validate, sweeps.
                o_ctrl.sweep = (i_stat.cmd == CMD_VALIDATE) ||
                               (i_stat.cmd == CMD_LOGIN && !i_stat.plen_bad &&
                                !i_stat.not_admin);
            end
            S_DECIDE: begin
                unique case (i_stat.cmd)
                    CMD_LOGIN: begin
                        priority if (i_stat.plen_bad) begin
                            o_ctrl.finish = 1'b1;
                            o_ctrl.status = ST_PARAM;
                        end else if (i_stat.not_admin || i_stat.hash_bad) begin
                            o_ctrl.finish = 1'b1;
                            o_ctrl.status = ST_CRED;
                        end else if (i_stat.full) begin
                            o_ctrl.finish = 1'b1;
                            o_ctrl.status = ST_FULL;
                        end else begin
                            // All checks passed: the draw follows.
                            o_ctrl.finish = 1'b0;
                        end
                    end
                    CMD_LOGOUT: begin
                        o_ctrl.finish     = 1'b1;
                        o_ctrl.logout_clr = i_stat.found;
                        o_ctrl.status     = i_stat.found ? ST_OK : ST_NOTFOUND;
                    end
                    CMD_VALIDATE: begin
                        o_ctrl.finish = 1'b1;
                        priority if (!i_stat.found) begin
                            o_ctrl.status = ST_NOTFOUND;
                        end else if (i_stat.expired) begin
                            o_ctrl.validate_exp = 1'b1;
                            o_ctrl.status       = ST_EXPIRED;
                        end else begin
                            o_ctrl.validate_upd = 1'b1;
                            o_ctrl.res          = RES_VALIDATE;
                        end
                    end
                    default: begin
                        o_ctrl.finish = 1'b1;
                        o_ctrl.status = ST_PARAM;
                    end
                endcase
            end
            S_DRAW: begin
                o_ctrl.draw_step = 1'b1;
                if (i_stat.id_free || i_stat.last_try) begin
                    o_ctrl.finish = 1'b1;
                    o_ctrl.res    = RES_LOGIN;
                end
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: sv/ste_datapath.sv
// Datapath of the session table: configuration, slot storage, request and result registers.
// Depends on ste_pkg; commanded by ste_ctrl.
`timescale 1ns / 1ps

module ste_datapath import ste_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [31:0]     i_cfg_data,
    input  logic [1:0]      i_command,
    input  logic [47:0]     i_now_ms,
    input  logic [15:0]     i_sess_id,
    input  logic            i_user_is_admin,
    input  logic [31:0]     i_password_hash,
    input  logic [7:0]      i_password_len,
    input  t_dp_ctrl        i_ctrl,
    output t_dp_stat        o_stat,
    output logic            o_done,
    output logic [2:0]      o_status,
    output logic [15:0]     o_granted_id,
    output logic [47:0]     o_login_stamp,
    output logic [47:0]     o_activity_stamp,
    output logic [47:0]     o_expiry_stamp
);

    // Configuration registers.
    logic        r_timeout_en;
    logic [31:0] r_timeout;
    logic [31:0] r_admin_hash;
    logic [7:0]  r_max_len;

    // Latched request.
    t_cmd        r_cmd;
    logic [47:0] r_now;
    logic [15:0] r_sid;
    logic        r_admin;
    logic [31:0] r_phash;
    logic [7:0]  r_plen;

    // Slot storage.
    logic [SLOTS-1:0]  r_active;
    logic [ID_W-1:0]   r_ident    [SLOTS];
    logic [TS_W-1:0]   r_login    [SLOTS];
    logic [TS_W-1:0]   r_activity [SLOTS];
    logic [TS_W-1:0]   r_expiry   [SLOTS];

    logic [ID_W-1:0]  r_next_ident;
    logic [IDX_W-1:0] r_tries;

    logic [SLOTS-1:0] expired_vec;
    logic [SLOTS-1:0] match_vec;
    logic [SLOTS-1:0] cand_vec;
    logic [IDX_W-1:0] find_idx;
    logic [IDX_W-1:0] free_idx;
    logic             found;
    logic             has_free;
    logic [TS_W:0]    exp_sum;
    logic [TS_W-1:0]  exp_calc;
    logic             alloc;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_en <= 1'b1;
            r_timeout    <= 32'd1800000;
            r_admin_hash <= 32'd0;
            r_max_len    <= 8'd64;
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_idx))
                REG_TIMEOUT_EN: r_timeout_en <= i_cfg_data[0];
                REG_TIMEOUT:    r_timeout    <= i_cfg_data;
                REG_ADMIN_HASH: r_admin_hash <= i_cfg_data;
                REG_MAX_LEN:    r_max_len    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_cmd   <= t_cmd'(i_command);
            r_now   <= i_now_ms;
            r_sid   <= i_sess_id;
            r_admin <= i_user_is_admin;
            r_phash <= i_password_hash;
            r_plen  <= i_password_len;
        end
    end

    // Per-slot compares: expiry against now, identifier against request and candidate.
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            expired_vec[i] = r_active[i] && (r_now > r_expiry[i]);
            match_vec[i]   = r_active[i] && (r_ident[i] == r_sid);
            cand_vec[i]    = r_active[i] && (r_ident[i] == r_next_ident);
        end
    end

    // Lowest matching slot and lowest free slot.
    always_comb begin
        found    = 1'b0;
        find_idx = '0;
        has_free = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (match_vec[i]) begin
                found    = 1'b1;
                find_idx = IDX_W'(i);
            end
            if (!r_active[i]) begin
                has_free = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // Expiry with saturation at the top of the time range.
    assign exp_sum  = {1'b0, r_now} + {17'd0, r_timeout};
    assign exp_calc = exp_sum[TS_W] ? {TS_W{1'b1}} : exp_sum[TS_W-1:0];

    assign alloc = i_ctrl.draw_step && i_ctrl.finish;

    // Status to the controller.
    always_comb begin
        o_stat.cmd       = r_cmd;
        o_stat.plen_bad  = (r_plen > r_max_len);
        o_stat.not_admin = !r_admin;
        o_stat.hash_bad  = (r_phash != r_admin_hash);
        o_stat.full      = !has_free;
        o_stat.found     = found;
        o_stat.expired   = r_timeout_en && (r_now > r_expiry[find_idx]);
        o_stat.id_free   = ~|cand_vec;
        o_stat.last_try  = (r_tries == IDX_W'(SLOTS - 1));
    end

    // Active flags: sweep, logout, expiry on validate, new session.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else begin
            if (i_ctrl.sweep && r_timeout_en) begin
                r_active <= r_active & ~expired_vec;
            end
            if (i_ctrl.logout_clr || i_ctrl.validate_exp) begin
                r_active[find_idx] <= 1'b0;
            end
            if (alloc) begin
                r_active[free_idx] <= 1'b1;
            end
        end
    end

    // Slot payload writes.
    always_ff @(posedge i_clk) begin
        if (alloc) begin
            r_ident[free_idx]    <= r_next_ident;
            r_login[free_idx]    <= r_now;
            r_activity[free_idx] <= r_now;
            r_expiry[free_idx]   <= exp_calc;
        end
        if (i_ctrl.validate_upd) begin
            r_activity[find_idx] <= r_now;
            r_expiry[find_idx]   <= exp_calc;
        end
    end

    // Identifier counter and the try count of the current draw.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_ident <= ID_W'(ID_FIRST);
            r_tries      <= '0;
        end else begin
            if (i_ctrl.capture) r_tries <= '0;
            if (i_ctrl.draw_step) begin
                r_tries <= r_tries + 1'b1;
                if (r_next_ident >= ID_W'(ID_LAST)) begin
                    r_next_ident <= ID_W'(ID_FIRST);
                end else begin
                    r_next_ident <= r_next_ident + 1'b1;
                end
            end
        end
    end

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= i_ctrl.finish;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.finish) begin
            o_status <= i_ctrl.status;
            unique case (i_ctrl.res)
                RES_LOGIN: begin
                    o_granted_id     <= r_next_ident;
                    o_login_stamp    <= r_now;
                    o_activity_stamp <= r_now;
                    o_expiry_stamp   <= exp_calc;
                end
                RES_VALIDATE: begin
                    o_granted_id     <= r_ident[find_idx];
                    o_login_stamp    <= r_login[find_idx];
                    o_activity_stamp <= r_now;
                    o_expiry_stamp   <= exp_calc;
                end
                default: begin
                    o_granted_id     <= '0;
                    o_login_stamp    <= '0;
                    o_activity_stamp <= '0;
                    o_expiry_stamp   <= '0;
                end
            endcase
        end
    end

endmodule

FILE: sv/ste_checker.sv
// Port-level checks of the session table, bound to the top level.
// Depends on assert_macros.svh and ste_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ste_checker import ste_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [2:0]  o_status,
    input logic [15:0] o_granted_id,
    input logic [47:0] o_login_stamp,
    input logic [47:0] o_activity_stamp,
    input logic [47:0] o_expiry_stamp
);

    // An accepted request keeps the block busy in the next cycle.
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "request not taken")

    // A result appears only once the block has gone idle.
    `ASSERT_SAME(a_done_idle, i_clk, i_rst_n, o_done, !busy, "result while busy")

    // Status codes stay in their defined range.
    `ASSERT_SAME(a_status_range, i_clk, i_rst_n, o_done, o_status <= ST_PARAM, "bad status")

    // A failing request carries an all-zero payload.
    `ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, o_done && o_status != ST_OK, (o_granted_id == '0) && (o_login_stamp == '0) && (o_activity_stamp == '0) && (o_expiry_stamp == '0), "nonzero payload on failure")

endmodule

bind session_table_with_expiry ste_checker u_chk (.*);
